>>> sv/mna_pkg.sv
// Shared constants and types for the minor number allocator.
`default_nettype none

package mna_pkg;

  localparam int DEF_MAX_IDS = 256;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);

  localparam int FUNC_W   = 2;
  localparam int ID_IN_W  = 8;
  localparam int ID_OUT_W = 8;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic {
    SRCH_LOW_ZERO = 1'b0,
    SRCH_HIGH_ONE = 1'b1
  } srch_mode_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } srch_res_t;

endpackage

`default_nettype wire

>>> sv/mna_if.sv
// Request and result channel interfaces.
`default_nettype none

interface mna_req_if;
  logic                         valid;
  logic                         ready;
  logic [mna_pkg::FUNC_W-1:0]   func;
  logic [mna_pkg::ID_IN_W-1:0]  id_in;

  modport source (output valid, func, id_in, input ready);
  modport sink   (input valid, func, id_in, output ready);
endinterface

interface mna_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [mna_pkg::ID_OUT_W-1:0] id_out;

  modport source (output valid, status, id_out, input ready);
  modport sink   (input valid, status, id_out, output ready);
endinterface

`default_nettype wire

>>> sv/mna_map_ram.sv
// Used-map word memory with per-row valid flags and registered read.
`default_nettype none

module mna_map_ram #(
  parameter int ROWS  = 8,
  parameter int ROW_W = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       we,
  input  wire logic [ROW_W-1:0]           waddr,
  input  wire logic [mna_pkg::WORD_W-1:0] wdata,
  input  wire logic [ROW_W-1:0]           raddr,
  output      logic [mna_pkg::WORD_W-1:0] rdata
);

  logic [mna_pkg::WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]            vld_r;
  logic [mna_pkg::WORD_W-1:0] rd_r;
  logic                       rd_vld_r;
  logic                       bypass;

  assign bypass = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= bypass ? wdata : mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= bypass || vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

`default_nettype wire

>>> sv/mna_bit_search.sv
// Shared word search: lowest clear bit under a mask, or highest set bit.
`default_nettype none

module mna_bit_search (
  input  wire logic [mna_pkg::WORD_W-1:0] word,
  input  wire logic [mna_pkg::WORD_W-1:0] mask,
  input  wire mna_pkg::srch_mode_t        mode,
  output      mna_pkg::srch_res_t         res
);

  logic [mna_pkg::WORD_W-1:0] cand;

  always_comb begin
    cand = (mode == mna_pkg::SRCH_LOW_ZERO) ? (~word & mask) : (word & mask);
    res  = '0;
    for (int i = 0; i < mna_pkg::WORD_W; i++) begin
      if (cand[i] && ((mode == mna_pkg::SRCH_HIGH_ONE) || !res.found)) begin
        res.found   = 1'b1;
        res.bit_idx = mna_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/minor_number_allocator_top.sv
// Top level: request sequencer, used-map, highest-ID tracking and result register.
// Claim and next-above-highest allocate: read-modify-write of one map row, then DONE and the result register.
// Release: clear the ID's bit (in-range IDs only), then a top-down row scan, one 32-bit row per cycle.
// Allocate falling back to lowest-free search scans the rows bottom-up from row 0.
// Ready rises again in the cycle after the result is registered; ROWS = MAX_IDS/32, rounded up.
// Reset clears row valid flags at once (no clearing pass); the ID count (cfg_cnt_r) resets to 256.
`default_nettype none

module minor_number_allocator_top #(
  parameter int MAX_IDS = mna_pkg::DEF_MAX_IDS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mna_req_if.sink                        in_req,
  mna_rsp_if.source                      out_rsp,
  input  wire logic                      cfg_we,
  input  wire logic [mna_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int WORD_W = mna_pkg::WORD_W;
  localparam int BIT_W  = mna_pkg::BIT_W;
  localparam int ROWS   = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FULL_W = ROW_W + BIT_W;
  localparam int CMP_W  = ((FULL_W > mna_pkg::CFG_W) ? FULL_W : mna_pkg::CFG_W) + 1;
  localparam logic [ROW_W-1:0] TOP_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RMW     = 5'b00010,
    ST_SCAN_UP = 5'b00100,
    ST_SCAN_DN = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [mna_pkg::CFG_W-1:0]       cfg_cnt_r;
  logic [mna_pkg::FUNC_W-1:0]      op_r, op_nxt;
  logic [FULL_W-1:0]               tgt_r, tgt_nxt;
  logic [FULL_W-1:0]               hi_r, hi_nxt;
  logic                            any_r, any_nxt;
  logic                            res_status_r, res_status_nxt;
  logic [mna_pkg::ID_OUT_W-1:0]    res_id_r, res_id_nxt;
  logic [ROW_W-1:0]                rd_row_r;
  logic                            out_valid_r;
  logic                            out_status_r;
  logic [mna_pkg::ID_OUT_W-1:0]    out_id_r;

  logic                            ram_we;
  logic [ROW_W-1:0]                ram_waddr;
  logic [WORD_W-1:0]               ram_wdata;
  logic [ROW_W-1:0]                ram_raddr;
  logic [WORD_W-1:0]               rd_data;

  logic [CMP_W-1:0]                cfg_ext, max_ext, eff, eff_row, row_ext, id_ext;
  logic [WORD_W-1:0]               lim_mask, srch_mask, tgt_bit, hit_bit;
  logic [FULL_W-1:0]               grant;
  logic [FULL_W-1:0]               in_tgt;
  mna_pkg::srch_mode_t             srch_mode;
  mna_pkg::srch_res_t              srch;
  logic                            accept, out_free;

  // effective count and per-row limit mask
  always_comb begin
    cfg_ext = CMP_W'(cfg_cnt_r);
    max_ext = CMP_W'(MAX_IDS);
    if (cfg_ext == '0) begin
      eff = CMP_W'(1);
    end else if (cfg_ext > max_ext) begin
      eff = max_ext;
    end else begin
      eff = cfg_ext;
    end
    eff_row = eff >> BIT_W;
    row_ext = CMP_W'(rd_row_r);
    if (row_ext < eff_row) begin
      lim_mask = '1;
    end else if (row_ext == eff_row) begin
      lim_mask = ~({WORD_W{1'b1}} << eff[BIT_W-1:0]);
    end else begin
      lim_mask = '0;
    end
  end

  assign srch_mode = (state_r == ST_SCAN_DN) ? mna_pkg::SRCH_HIGH_ONE : mna_pkg::SRCH_LOW_ZERO;
  assign srch_mask = (state_r == ST_SCAN_DN) ? '1 : lim_mask;

  mna_bit_search u_search (
    .word (rd_data),
    .mask (srch_mask),
    .mode (srch_mode),
    .res  (srch)
  );

  mna_map_ram #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign id_ext       = CMP_W'(in_req.id_in);
  assign in_tgt       = FULL_W'(in_req.id_in);
  assign tgt_bit      = WORD_W'(1) << tgt_r[BIT_W-1:0];
  assign hit_bit      = WORD_W'(1) << srch.bit_idx;
  assign grant        = {rd_row_r, srch.bit_idx};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    tgt_nxt        = tgt_r;
    hi_nxt         = hi_r;
    any_nxt        = any_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    ram_we         = 1'b0;
    ram_waddr      = tgt_r[FULL_W-1:BIT_W];
    ram_wdata      = rd_data | tgt_bit;
    ram_raddr      = rd_row_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_req.func;
          tgt_nxt        = in_tgt;
          res_status_nxt = mna_pkg::STATUS_DONE;
          res_id_nxt     = in_req.id_in;
          state_nxt      = ST_DONE;
          case (in_req.func)
            mna_pkg::FUNC_ALLOC: begin
              if (!any_r) begin
                tgt_nxt   = '0;
                ram_raddr = '0;
                state_nxt = ST_RMW;
              end else if ((CMP_W'(hi_r) + CMP_W'(1)) < eff) begin
                tgt_nxt   = FULL_W'(hi_r + FULL_W'(1));
                ram_raddr = tgt_nxt[FULL_W-1:BIT_W];
                state_nxt = ST_RMW;
              end else begin
                ram_raddr = '0;
                state_nxt = ST_SCAN_UP;
              end
            end
            mna_pkg::FUNC_CLAIM: begin
              if (id_ext < max_ext) begin
                ram_raddr = in_tgt[FULL_W-1:BIT_W];
                state_nxt = ST_RMW;
              end
            end
            mna_pkg::FUNC_RELEASE: begin
              if (id_ext < max_ext) begin
                ram_raddr = in_tgt[FULL_W-1:BIT_W];
                state_nxt = ST_RMW;
              end else begin
                ram_raddr = TOP_ROW;
                state_nxt = ST_SCAN_DN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        ram_we = 1'b1;
        if (op_r == mna_pkg::FUNC_RELEASE) begin
          ram_wdata = rd_data & ~tgt_bit;
          ram_raddr = TOP_ROW;
          state_nxt = ST_SCAN_DN;
        end else begin
          if (!any_r || (tgt_r > hi_r)) begin
            hi_nxt = tgt_r;
          end
          any_nxt = 1'b1;
          if (op_r == mna_pkg::FUNC_ALLOC) begin
            res_id_nxt = mna_pkg::ID_OUT_W'(tgt_r);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN_UP: begin
        if (srch.found) begin
          ram_we    = 1'b1;
          ram_waddr = rd_row_r;
          ram_wdata = rd_data | hit_bit;
          if (!any_r || (grant > hi_r)) begin
            hi_nxt = grant;
          end
          any_nxt    = 1'b1;
          res_id_nxt = mna_pkg::ID_OUT_W'(grant);
          state_nxt  = ST_DONE;
        end else if (rd_row_r == TOP_ROW) begin
          res_status_nxt = mna_pkg::STATUS_FULL;
          res_id_nxt     = '0;
          state_nxt      = ST_DONE;
        end else begin
          ram_raddr = ROW_W'(rd_row_r + ROW_W'(1));
        end
      end
      ST_SCAN_DN: begin
        if (srch.found) begin
          hi_nxt    = grant;
          any_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (rd_row_r == '0) begin
          hi_nxt    = '0;
          any_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          ram_raddr = ROW_W'(rd_row_r - ROW_W'(1));
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_cnt_r   <= mna_pkg::CFG_RESET;
      hi_r        <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r    <= hi_nxt;
      any_r   <= any_nxt;
      if (cfg_we) begin
        cfg_cnt_r <= cfg_wdata;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tgt_r        <= tgt_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    rd_row_r     <= ram_raddr;
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.id_out = out_id_r;

  a_hi_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> hi_r == '0)
    else $error("highest ID nonzero while map empty");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready)
    else $error("request taken while previous one still in progress");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_RMW || state_r == ST_SCAN_UP))
    else $error("map written outside a modify state");

  a_full_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status == mna_pkg::STATUS_FULL |-> out_rsp.id_out == '0)
    else $error("full result with nonzero ID");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_rsp.valid && state_r == ST_IDLE)
    else $error("finished request not presented");

endmodule

`default_nettype wire

>>> sim/mna_checker.sv
// Checker for the minor number allocator: tracks the ID map, predicts each result, compares.
`timescale 1ns / 1ps

module mna_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  mna_req_if                        req,
  mna_rsp_if                        rsp,
  input  logic                      cfg_we,
  input  logic [mna_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic                         status;
    logic [mna_pkg::ID_OUT_W-1:0] id;
  } grant_t;

  logic [mna_pkg::DEF_MAX_IDS-1:0] id_used;
  int unsigned                     top_id;
  logic                            any_id;
  logic [mna_pkg::CFG_W-1:0]       id_limit;
  grant_t                          grant_q[$];
  int                              fails = 0;

  function automatic int unsigned usable_ids();
    int unsigned c;
    c = 32'(id_limit);
    if (c < 1) c = 1;
    if (c > mna_pkg::DEF_MAX_IDS) c = mna_pkg::DEF_MAX_IDS;
    return c;
  endfunction

  function automatic void take_id(int unsigned id);
    id_used[id] = 1'b1;
    if (!any_id || id > top_id) top_id = id;
    any_id = 1'b1;
  endfunction

  function automatic void rescan_top();
    top_id = 0;
    any_id = 1'b0;
    for (int i = mna_pkg::DEF_MAX_IDS - 1; i >= 0; i--) begin
      if (id_used[i]) begin
        top_id = i;
        any_id = 1'b1;
        break;
      end
    end
  endfunction

  function automatic grant_t serve_req(logic [mna_pkg::FUNC_W-1:0] f,
                                       logic [mna_pkg::ID_IN_W-1:0] id);
    grant_t      g;
    int unsigned cnt;
    int unsigned pick;
    logic        hit;
    g.status = mna_pkg::STATUS_DONE;
    g.id     = id;
    case (f)
      mna_pkg::FUNC_ALLOC: begin
        cnt  = usable_ids();
        hit  = 1'b0;
        pick = 0;
        if (!any_id) begin
          hit = 1'b1;
        end else if (top_id + 1 < cnt) begin
          pick = top_id + 1;
          hit  = 1'b1;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (!id_used[i]) begin
              pick = i;
              hit  = 1'b1;
              break;
            end
          end
        end
        if (hit) begin
          take_id(pick);
          g.id = pick[mna_pkg::ID_OUT_W-1:0];
        end else begin
          g.status = mna_pkg::STATUS_FULL;
          g.id     = '0;
        end
      end
      mna_pkg::FUNC_CLAIM: take_id(32'(id));
      mna_pkg::FUNC_RELEASE: begin
        id_used[id] = 1'b0;
        rescan_top();
      end
      default: ;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      id_used  = '0;
      top_id   = 0;
      any_id   = 1'b0;
      id_limit = mna_pkg::CFG_RESET;
      grant_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) id_limit = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $error("result with no request outstanding: status %0d id_out %0d",
                 rsp.status, rsp.id_out);
          fails++;
        end else begin
          want = grant_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.id_out !== want.id) begin
            $error("id_out: expected %0d, actual %0d", want.id, rsp.id_out);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) grant_q.push_back(serve_req(req.func, req.id_in));
      pending <= grant_q.size();
    end
    fail_count <= fails;
  end

endmodule

>>> sim/tb_minor_number_allocator_top.sv
// Testbench top for the minor number allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_minor_number_allocator_top;

  localparam logic [mna_pkg::CFG_W-1:0] PHASE_CNT [7] = '{9'd256, 9'd32, 9'd3, 9'd64,
                                                          9'd8, 9'd1, 9'd200};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [mna_pkg::CFG_W-1:0] cfg_wdata;
  logic                      no_idle;
  logic                      hold_tog;
  int                        fail_count;
  int                        pending;
  int                        eff_cnt;

  mna_req_if req_ch ();
  mna_rsp_if rsp_ch ();

  minor_number_allocator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mna_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure, plus one long hold when hold_tog flips
  initial begin : rsp_side
    logic seen;
    int   hold_left;
    seen          = 1'b0;
    hold_left     = 0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog != seen) begin
        seen      = hold_tog;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  task automatic send_req(input logic [mna_pkg::FUNC_W-1:0] f,
                          input logic [mna_pkg::ID_IN_W-1:0] id);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.id_in <= id;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic set_count(input logic [mna_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    eff_cnt = (v == 0) ? 1 :
              (v > mna_pkg::DEF_MAX_IDS) ? mna_pkg::DEF_MAX_IDS : int'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [mna_pkg::FUNC_W-1:0] next_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return mna_pkg::FUNC_ALLOC;
    if (r < 65) return mna_pkg::FUNC_CLAIM;
    if (r < 95) return mna_pkg::FUNC_RELEASE;
    return ~mna_pkg::FUNC_ALLOC;
  endfunction

  function automatic logic [mna_pkg::ID_IN_W-1:0] next_id();
    int hi;
    if ($urandom_range(0, 3) == 0) return mna_pkg::ID_IN_W'($urandom_range(0, 255));
    hi = (eff_cnt + 1 > 255) ? 255 : eff_cnt + 1;
    return mna_pkg::ID_IN_W'($urandom_range(0, hi));
  endfunction

  initial begin : stim
    req_ch.valid = 1'b0;
    req_ch.func  = mna_pkg::FUNC_ALLOC;
    req_ch.id_in = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = mna_pkg::CFG_RESET;
    no_idle      = 1'b0;
    hold_tog     = 1'b0;
    eff_cnt      = mna_pkg::DEF_MAX_IDS;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty map, next-above-highest, fallback to lowest free
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_ALLOC, 8'd77);
    send_req(mna_pkg::FUNC_CLAIM, 8'd255);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_CLAIM, 8'd2);
    send_req(mna_pkg::FUNC_RELEASE, 8'd100);
    send_req(mna_pkg::FUNC_RELEASE, 8'd255);
    send_req(~mna_pkg::FUNC_ALLOC, 8'hAA);
    send_req(~mna_pkg::FUNC_ALLOC, 8'h55);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_CLAIM, 8'd0);
    send_req(mna_pkg::FUNC_RELEASE, 8'd0);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);

    // zero count behaves as one: fills at once, then full
    wait_idle();
    set_count(9'd0);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_CLAIM, 8'd200);
    send_req(mna_pkg::FUNC_RELEASE, 8'd200);

    // over-range count clamps to the map size
    wait_idle();
    set_count(9'h1FF);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_CLAIM, 8'd128);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);

    wait_idle();
    set_count(9'd2);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);
    send_req(mna_pkg::FUNC_RELEASE, 8'd1);
    send_req(mna_pkg::FUNC_ALLOC, 8'd0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_count(p == 7 ? 9'($urandom_range(0, 511)) : PHASE_CNT[p]);
      no_idle <= (p == 1);
      if (p == 2) hold_tog <= ~hold_tog;
      if (p == 4) begin
        for (int i = 0; i < mna_pkg::DEF_MAX_IDS; i++) begin
          send_req(mna_pkg::FUNC_RELEASE, i[mna_pkg::ID_IN_W-1:0]);
        end
      end
      repeat (125) send_req(next_func(), next_id());
    end

    wait_idle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
